// ----- src/wpt_pkg.sv -----
// Shared types and constants of the wide polyline triangulator.
// Used by the iterative square root, the divider and the top level.
package wpt_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_SLOPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Z_FAR       = 2'd2;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_POINT = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam logic [30:0] MIN_WIDTH_RESET = 31'd655;

   localparam int DIV_NUM_W  = 48;
   localparam int DIV_DEN_W  = 31;
   localparam int SQRT_IN_W  = 64;
   localparam int SQRT_OUT_W = SQRT_IN_W / 2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               tri_index;
      logic [1:0]         corner;
      logic               last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_NRM_SHIFT,
      ST_NRM_SQX,
      ST_NRM_SQY,
      ST_NRM_SUM,
      ST_NRM_SQRT,
      ST_NRM_DIVX,
      ST_NRM_DIVY,
      ST_DOT1,
      ST_DOT2,
      ST_DOT3,
      ST_W1,
      ST_W2,
      ST_OFX,
      ST_OFY,
      ST_CORN,
      ST_E_N1,
      ST_E_N2,
      ST_E_N3,
      ST_E_SQ,
      ST_E_DX,
      ST_E_DY,
      ST_E_DZ,
      ST_E_OUT
   } state_type;

endpackage

// ----- src/wpt_isqrt.sv -----
// Iterative floor integer square root, one result bit per cycle.
// Depends on wpt_pkg for widths.
module wpt_isqrt
   import wpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SQRT_IN_W-1:0]  value,
   output logic                  done,
   output logic [SQRT_OUT_W-1:0] root
);

   localparam int CntW = $clog2(SQRT_OUT_W + 1);
   localparam int RemW = SQRT_OUT_W + 2;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [SQRT_IN_W-1:0]  val_ff, val_in;
   logic [RemW-1:0]       rem_ff, rem_in;
   logic [SQRT_OUT_W-1:0] root_ff, root_in;
   logic [RemW+1:0]       trial_rem;
   logic [RemW+1:0]       trial;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      trial_rem = {rem_ff, val_ff[SQRT_IN_W-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(SQRT_OUT_W);
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[SQRT_IN_W-3:0], 2'b00};
         if (trial_rem >= trial) begin
            rem_in  = RemW'(trial_rem - trial);
            root_in = {root_ff[SQRT_OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = RemW'(trial_rem);
            root_in = {root_ff[SQRT_OUT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- src/wpt_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wpt_pkg for widths.
module wpt_div
   import wpt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CntW = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] sh_ff, sh_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, sh_ff[DIV_NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DIV_NUM_W);
         sh_in   = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            sh_in  = {sh_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = DIV_DEN_W'(trial);
            sh_in  = {sh_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = sh_ff;

endmodule

// ----- src/wide_polyline_triangulator_top.sv -----
// Top level of the wide polyline triangulator: sequencer, shared multiplier, state.
// Depends on wpt_pkg, wpt_isqrt and wpt_div.
//
// Strokes polyline commands into quads of two triangles, one vertex per rsp transfer.
// One item is worked at a time and req_ready is high only while the block is idle.
// Start and unknown commands are taken in the idle state; a first point passes through
// the prep state. A unit-direction normalization runs up to 29 one-bit scaling shifts,
// then the squares, the bit-per-cycle square root and two divisions. The second point
// adds one normalization and the width and corner states. Each further point adds two
// normalizations, the width and corner states and six vertices (one root and three
// divisions each), plus any rsp stall.
module wide_polyline_triangulator_top
   import wpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type state_ff, state_in;

   logic [30:0]        minw_ff, minw_in;
   logic signed [31:0] slope_ff, slope_in;
   logic signed [31:0] zfar_ff, zfar_in;

   logic [1:0]         pcnt_ff, pcnt_in;
   logic               sharp_ff, sharp_in;
   logic               bend_ff, bend_in;
   logic               phase_ff, phase_in;
   logic signed [31:0] lp_ff [4];
   logic signed [31:0] lp_in [4];
   logic signed [17:0] ldir_ff [2];
   logic signed [17:0] ldir_in [2];
   logic signed [31:0] pc_ff [8];
   logic signed [31:0] pc_in [8];
   logic signed [17:0] pn_ff [4];
   logic signed [17:0] pn_in [4];
   logic signed [31:0] nc_ff [8];
   logic signed [31:0] nc_in [8];
   logic signed [17:0] nn_ff [4];
   logic signed [17:0] nn_in [4];
   logic signed [31:0] pt_ff [4];
   logic signed [31:0] pt_in [4];

   logic [33:0]        nmx_ff, nmx_in;
   logic [33:0]        nmy_ff, nmy_in;
   logic               nsx_ff, nsx_in;
   logic               nsy_ff, nsy_in;
   logic [16:0]        nqx_ff, nqx_in;
   logic signed [17:0] u_ff [2];
   logic signed [17:0] u_in [2];
   logic signed [17:0] cd_ff [2];
   logic signed [17:0] cd_in [2];
   logic [31:0]        len_ff, len_in;
   logic signed [67:0] prod_ff;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [31:0] w_ff, w_in;
   logic signed [32:0] offx_ff, offx_in;
   logic [2:0]         k_ff, k_in;
   logic signed [17:0] en_ff [2];
   logic signed [17:0] en_in [2];
   logic [15:0]        nox_ff, nox_in;
   logic [15:0]        noy_ff, noy_in;
   logic [15:0]        noz_ff, noz_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;

   logic                  div_start, div_done;
   logic [DIV_NUM_W-1:0]  div_num, div_quo;
   logic [DIV_DEN_W-1:0]  div_den;
   logic                  sqrt_start, sqrt_done;
   logic [SQRT_IN_W-1:0]  sqrt_val;
   logic [SQRT_OUT_W-1:0] sqrt_root;

   logic [33:0]        nrm_m;
   logic signed [32:0] dd_x, dd_y;
   logic               nrm_fin;
   logic signed [17:0] nrm_rx, nrm_ry;
   logic signed [67:0] dot_sum;
   logic signed [18:0] bis_x, bis_y;
   logic signed [32:0] offy_now;
   logic signed [31:0] nc_calc [8];
   logic signed [17:0] nn_calc [4];
   logic [1:0]         slot;
   logic signed [31:0] vsel [4];
   logic signed [17:0] nsel [2];
   logic               tri_now;
   logic [1:0]         corner_now;
   logic               out_free;

   function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
      if (v[52:31] == {22{v[52]}}) begin
         sat32 = v[31:0];
      end else if (v[52]) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = 32'sh7FFF_FFFF;
      end
   endfunction

   function automatic logic signed [52:0] rnd16(input logic signed [67:0] p);
      logic [67:0] mg;
      logic [67:0] r;
      mg = p[67] ? 68'(-p) : 68'(p);
      r  = (mg + 68'h8000) >> 16;
      rnd16 = p[67] ? -$signed(r[52:0]) : $signed(r[52:0]);
   endfunction

   function automatic logic [33:0] mag34(input logic signed [33:0] v);
      mag34 = v[33] ? 34'(-v) : 34'(v);
   endfunction

   function automatic logic [16:0] mag18(input logic signed [17:0] v);
      logic signed [17:0] a;
      a = v[17] ? -v : v;
      mag18 = a[16:0];
   endfunction

   function automatic logic [16:0] clamp_unit(input logic [DIV_NUM_W-1:0] q);
      clamp_unit = (q > DIV_NUM_W'(65536)) ? 17'd65536 : q[16:0];
   endfunction

   function automatic logic signed [17:0] apply_sign(input logic neg, input logic [16:0] q);
      apply_sign = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   function automatic logic [15:0] sat_q15(input logic [DIV_NUM_W-1:0] q, input logic neg);
      if (neg) begin
         sat_q15 = (q > DIV_NUM_W'(32768)) ? 16'h8000 : 16'd0 - q[15:0];
      end else begin
         sat_q15 = (q > DIV_NUM_W'(32767)) ? 16'h7FFF : q[15:0];
      end
   endfunction

   wpt_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_val),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   wpt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign mul_p = mul_a * mul_b;

   always_comb begin
      nrm_m   = (nmx_ff > nmy_ff) ? nmx_ff : nmy_ff;
      dd_x    = 33'(pt_ff[0]) - 33'(lp_ff[0]);
      dd_y    = 33'(pt_ff[1]) - 33'(lp_ff[1]);
      dot_sum = acc_ff + prod_ff;
      if (dot_sum > 68'sd0) begin
         bis_x = 19'(ldir_ff[0]) + 19'(u_ff[0]);
         bis_y = 19'(ldir_ff[1]) + 19'(u_ff[1]);
      end else begin
         bis_x = 19'(ldir_ff[0]) - 19'(u_ff[0]);
         bis_y = 19'(ldir_ff[1]) - 19'(u_ff[1]);
      end
      nrm_fin = ((state_ff == ST_NRM_SHIFT) && (nrm_m == '0)) ||
                ((state_ff == ST_NRM_DIVY) && div_done);
      if (state_ff == ST_NRM_SHIFT) begin
         nrm_rx = '0;
         nrm_ry = '0;
      end else begin
         nrm_rx = apply_sign(nsx_ff, nqx_ff);
         nrm_ry = apply_sign(nsy_ff, clamp_unit(div_quo));
      end
      offy_now   = 33'(rnd16(prod_ff));
      nc_calc[0] = sat32(53'(lp_ff[0]) - 53'(offy_now));
      nc_calc[1] = sat32(53'(lp_ff[1]) + 53'(offx_ff));
      nc_calc[2] = lp_ff[2];
      nc_calc[3] = lp_ff[3];
      nc_calc[4] = sat32(53'(lp_ff[0]) + 53'(offy_now));
      nc_calc[5] = sat32(53'(lp_ff[1]) - 53'(offx_ff));
      nc_calc[6] = lp_ff[2];
      nc_calc[7] = lp_ff[3];
      nn_calc[0] = -cd_ff[1];
      nn_calc[1] = cd_ff[0];
      nn_calc[2] = cd_ff[1];
      nn_calc[3] = -cd_ff[0];
      case (k_ff)
         3'd0:    slot = 2'd0;
         3'd1:    slot = 2'd1;
         3'd2:    slot = 2'd3;
         3'd3:    slot = 2'd0;
         3'd4:    slot = 2'd3;
         3'd5:    slot = 2'd2;
         default: slot = 2'd0;
      endcase
      tri_now    = (k_ff >= 3'd3);
      corner_now = tri_now ? 2'(k_ff - 3'd3) : 2'(k_ff);
      for (int i = 0; i < 4; i++) begin
         case (slot)
            2'd0:    vsel[i] = sharp_ff ? pc_ff[4+i] : pc_ff[i];
            2'd1:    vsel[i] = sharp_ff ? pc_ff[i] : pc_ff[4+i];
            2'd2:    vsel[i] = nc_ff[i];
            default: vsel[i] = nc_ff[4+i];
         endcase
      end
      for (int i = 0; i < 2; i++) begin
         case (slot)
            2'd0:    nsel[i] = sharp_ff ? pn_ff[2+i] : pn_ff[i];
            2'd1:    nsel[i] = sharp_ff ? pn_ff[i] : pn_ff[2+i];
            2'd2:    nsel[i] = nn_ff[i];
            default: nsel[i] = nn_ff[2+i];
         endcase
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_data.command == CMD_POINT ||
                              req_data.command == CMD_END)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (pcnt_ff == 2'd0 || (dd_x == '0 && dd_y == '0)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_NRM_SHIFT;
            end
         end
         ST_NRM_SHIFT: begin
            if (nrm_m != '0 && nrm_m[33:30] == '0 && nrm_m[29]) begin
               state_in = ST_NRM_SQX;
            end
         end
         ST_NRM_SQX:  state_in = ST_NRM_SQY;
         ST_NRM_SQY:  state_in = ST_NRM_SUM;
         ST_NRM_SUM:  state_in = ST_NRM_SQRT;
         ST_NRM_SQRT: if (sqrt_done) state_in = ST_NRM_DIVX;
         ST_NRM_DIVX: if (div_done) state_in = ST_NRM_DIVY;
         ST_NRM_DIVY: ;
         ST_DOT1:     state_in = ST_DOT2;
         ST_DOT2:     state_in = ST_DOT3;
         ST_DOT3:     state_in = ST_NRM_SHIFT;
         ST_W1:       state_in = ST_W2;
         ST_W2:       state_in = ST_OFX;
         ST_OFX:      state_in = ST_OFY;
         ST_OFY:      state_in = ST_CORN;
         ST_CORN:     state_in = (pcnt_ff == 2'd1) ? ST_IDLE : ST_E_N1;
         ST_E_N1:     state_in = ST_E_N2;
         ST_E_N2:     state_in = ST_E_N3;
         ST_E_N3:     state_in = ST_E_SQ;
         ST_E_SQ:     if (sqrt_done) state_in = ST_E_DX;
         ST_E_DX:     if (div_done) state_in = ST_E_DY;
         ST_E_DY:     if (div_done) state_in = ST_E_DZ;
         ST_E_DZ:     if (div_done) state_in = ST_E_OUT;
         ST_E_OUT: begin
            if (out_free) begin
               state_in = (k_ff == 3'd5) ? ST_IDLE : ST_E_N1;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
      if (nrm_fin) begin
         state_in = (phase_ff || pcnt_ff == 2'd1) ? ST_W1 : ST_DOT1;
      end
   end

   always_comb begin
      minw_in      = minw_ff;
      slope_in     = slope_ff;
      zfar_in      = zfar_ff;
      pcnt_in      = pcnt_ff;
      sharp_in     = sharp_ff;
      bend_in      = bend_ff;
      phase_in     = phase_ff;
      lp_in        = lp_ff;
      ldir_in      = ldir_ff;
      pc_in        = pc_ff;
      pn_in        = pn_ff;
      nc_in        = nc_ff;
      nn_in        = nn_ff;
      pt_in        = pt_ff;
      nmx_in       = nmx_ff;
      nmy_in       = nmy_ff;
      nsx_in       = nsx_ff;
      nsy_in       = nsy_ff;
      nqx_in       = nqx_ff;
      u_in         = u_ff;
      cd_in        = cd_ff;
      len_in       = len_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      offx_in      = offx_ff;
      k_in         = k_ff;
      en_in        = en_ff;
      nox_in       = nox_ff;
      noy_in       = noy_ff;
      noz_in       = noz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = len_ff[DIV_DEN_W-1:0];
      sqrt_start   = 1'b0;
      sqrt_val     = '0;

      if (csr_wr_en) begin
         case (csr_index)
            REG_MIN_WIDTH:   minw_in  = csr_data[30:0];
            REG_WIDTH_SLOPE: slope_in = $signed(csr_data);
            REG_Z_FAR:       zfar_in  = $signed(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.command)
                  CMD_START: begin
                     pcnt_in  = 2'd0;
                     sharp_in = 1'b0;
                  end
                  CMD_POINT: begin
                     pt_in[0] = req_data.pos_x;
                     pt_in[1] = req_data.pos_y;
                     pt_in[2] = req_data.pos_z;
                     pt_in[3] = req_data.pos_w;
                  end
                  CMD_END: begin
                     pt_in[0] = sat32(53'(lp_ff[0]) + 53'(ldir_ff[0]));
                     pt_in[1] = sat32(53'(lp_ff[1]) + 53'(ldir_ff[1]));
                     pt_in[2] = lp_ff[2];
                     pt_in[3] = lp_ff[3];
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            if (pcnt_ff == 2'd0) begin
               lp_in   = pt_ff;
               pcnt_in = 2'd1;
            end else begin
               nmx_in   = mag34(34'(dd_x));
               nmy_in   = mag34(34'(dd_y));
               nsx_in   = dd_x[32];
               nsy_in   = dd_y[32];
               phase_in = 1'b0;
            end
         end
         ST_NRM_SHIFT: begin
            if (nrm_m[33:30] != '0) begin
               nmx_in = nmx_ff >> 1;
               nmy_in = nmy_ff >> 1;
            end else if (nrm_m != '0 && !nrm_m[29]) begin
               nmx_in = nmx_ff << 1;
               nmy_in = nmy_ff << 1;
            end
         end
         ST_NRM_SQX: begin
            mul_a = $signed(nmx_ff);
            mul_b = $signed(nmx_ff);
         end
         ST_NRM_SQY: begin
            acc_in = prod_ff;
            mul_a  = $signed(nmy_ff);
            mul_b  = $signed(nmy_ff);
         end
         ST_NRM_SUM: begin
            sqrt_start = 1'b1;
            sqrt_val   = SQRT_IN_W'(dot_sum);
         end
         ST_NRM_SQRT: begin
            if (sqrt_done) begin
               len_in    = sqrt_root;
               div_start = 1'b1;
               div_num   = DIV_NUM_W'({nmx_ff[29:0], 16'b0}) + DIV_NUM_W'(sqrt_root >> 1);
               div_den   = sqrt_root[DIV_DEN_W-1:0];
            end
         end
         ST_NRM_DIVX: begin
            if (div_done) begin
               nqx_in    = clamp_unit(div_quo);
               div_start = 1'b1;
               div_num   = DIV_NUM_W'({nmy_ff[29:0], 16'b0}) + DIV_NUM_W'(len_ff >> 1);
            end
         end
         ST_DOT1: begin
            mul_a = 34'(ldir_ff[0]);
            mul_b = 34'(u_ff[0]);
         end
         ST_DOT2: begin
            acc_in = prod_ff;
            mul_a  = 34'(ldir_ff[1]);
            mul_b  = 34'(u_ff[1]);
         end
         ST_DOT3: begin
            bend_in  = !(dot_sum > 68'sd0);
            nmx_in   = mag34(34'(bis_x));
            nmy_in   = mag34(34'(bis_y));
            nsx_in   = bis_x[18];
            nsy_in   = bis_y[18];
            phase_in = 1'b1;
         end
         ST_W1: begin
            mul_a = 34'(33'(lp_ff[2]) - 33'(zfar_ff));
            mul_b = 34'(slope_ff);
         end
         ST_W2: begin
            w_in = sat32(rnd16(prod_ff) + $signed(53'(minw_ff)));
         end
         ST_OFX: begin
            mul_a = 34'(w_ff);
            mul_b = 34'(cd_ff[0]);
         end
         ST_OFY: begin
            offx_in = 33'(rnd16(prod_ff));
            mul_a   = 34'(w_ff);
            mul_b   = 34'(cd_ff[1]);
         end
         ST_CORN: begin
            if (pcnt_ff == 2'd1) begin
               pc_in   = nc_calc;
               pn_in   = nn_calc;
               pcnt_in = 2'd2;
               lp_in   = pt_ff;
               ldir_in = u_ff;
            end else begin
               nc_in = nc_calc;
               nn_in = nn_calc;
               k_in  = 3'd0;
            end
         end
         ST_E_N1: begin
            en_in = nsel;
            mul_a = 34'(nsel[0]);
            mul_b = 34'(nsel[0]);
         end
         ST_E_N2: begin
            acc_in = prod_ff;
            mul_a  = 34'(en_ff[1]);
            mul_b  = 34'(en_ff[1]);
         end
         ST_E_N3: begin
            sqrt_start = 1'b1;
            sqrt_val   = SQRT_IN_W'(dot_sum) + SQRT_IN_W'(32'h4000_0000);
         end
         ST_E_SQ: begin
            if (sqrt_done) begin
               len_in    = sqrt_root;
               div_start = 1'b1;
               div_num   = DIV_NUM_W'({mag18(en_ff[0]), 15'b0}) +
                           DIV_NUM_W'(sqrt_root >> 1);
               div_den   = sqrt_root[DIV_DEN_W-1:0];
            end
         end
         ST_E_DX: begin
            if (div_done) begin
               nox_in    = sat_q15(div_quo, en_ff[0][17]);
               div_start = 1'b1;
               div_num   = DIV_NUM_W'({mag18(en_ff[1]), 15'b0}) + DIV_NUM_W'(len_ff >> 1);
            end
         end
         ST_E_DY: begin
            if (div_done) begin
               noy_in    = sat_q15(div_quo, en_ff[1][17]);
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(32'h4000_0000) + DIV_NUM_W'(len_ff >> 1);
            end
         end
         ST_E_DZ: begin
            if (div_done) begin
               noz_in = sat_q15(div_quo, 1'b1);
            end
         end
         ST_E_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_x     = vsel[0];
               rsp_data_in.out_y     = vsel[1];
               rsp_data_in.out_z     = vsel[2];
               rsp_data_in.out_w     = vsel[3];
               rsp_data_in.normal_x  = $signed(nox_ff);
               rsp_data_in.normal_y  = $signed(noy_ff);
               rsp_data_in.normal_z  = $signed(noz_ff);
               rsp_data_in.tri_index = tri_now;
               rsp_data_in.corner    = corner_now;
               rsp_data_in.last      = (k_ff == 3'd5);
               if (k_ff == 3'd5) begin
                  pc_in    = nc_ff;
                  pn_in    = nn_ff;
                  sharp_in = bend_ff;
                  lp_in    = pt_ff;
                  ldir_in  = u_ff;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end
         default: ;
      endcase

      if (nrm_fin) begin
         if (phase_ff) begin
            cd_in[0] = nrm_rx;
            cd_in[1] = nrm_ry;
         end else begin
            u_in[0] = nrm_rx;
            u_in[1] = nrm_ry;
            if (pcnt_ff == 2'd1) begin
               cd_in[0] = nrm_rx;
               cd_in[1] = nrm_ry;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         minw_ff      <= MIN_WIDTH_RESET;
         slope_ff     <= '0;
         zfar_ff      <= '0;
         pcnt_ff      <= 2'd0;
         sharp_ff     <= 1'b0;
         lp_ff        <= '{default: '0};
         ldir_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         minw_ff      <= minw_in;
         slope_ff     <= slope_in;
         zfar_ff      <= zfar_in;
         pcnt_ff      <= pcnt_in;
         sharp_ff     <= sharp_in;
         lp_ff        <= lp_in;
         ldir_ff      <= ldir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bend_ff     <= bend_in;
      phase_ff    <= phase_in;
      pc_ff       <= pc_in;
      pn_ff       <= pn_in;
      nc_ff       <= nc_in;
      nn_ff       <= nn_in;
      pt_ff       <= pt_in;
      nmx_ff      <= nmx_in;
      nmy_ff      <= nmy_in;
      nsx_ff      <= nsx_in;
      nsy_ff      <= nsy_in;
      nqx_ff      <= nqx_in;
      u_ff        <= u_in;
      cd_ff       <= cd_in;
      len_ff      <= len_in;
      prod_ff     <= mul_p;
      acc_ff      <= acc_in;
      w_ff        <= w_in;
      offx_ff     <= offx_in;
      k_ff        <= k_in;
      en_ff       <= en_in;
      nox_ff      <= nox_in;
      noy_ff      <= noy_in;
      noz_ff      <= noz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench of the wide polyline triangulator stroking unit.
// Drives polyline commands and CSR settings, predicts the triangle vertices in a
// behavioral model of the stroker, and compares each rsp transfer. Depends on wpt_pkg.
`timescale 1ns / 100ps

module testbench;
   import wpt_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   wide_polyline_triangulator_top i_dut (.*);

   // stroker state and settings
   logic [30:0]        m_min_width;
   logic signed [31:0] m_slope;
   logic signed [31:0] m_zfar;
   int                 m_count;
   bit                 m_sharp;
   logic signed [31:0] m_last_pt[4];
   logic signed [31:0] m_last_dir[2];
   logic signed [31:0] m_corners[8];
   logic signed [31:0] m_corner_nrm[4];

   req_type  pending_cmds[$];
   rsp_type  expected_vertices[$];
   int       errors;
   longint   cycle_count;
   bit       driver_done;
   int       hold_off;
   int       send_gap;
   int       recv_gap;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint round_shift(longint v, int s);
      longint unsigned q;
      q = (mag(v) + (64'd1 << (s - 1))) >> s;
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic unit_dir(input longint ax, input longint ay,
                           output logic signed [31:0] ox, output logic signed [31:0] oy);
      longint unsigned ux, uy, m, len, qx, qy;
      ux = mag(ax);
      uy = mag(ay);
      m = ux > uy ? ux : uy;
      if (m == 0) begin
         ox = 0;
         oy = 0;
         return;
      end
      while (m >= (64'd1 << 30)) begin
         ux = ux >> 1; uy = uy >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 29)) begin
         ux = ux << 1; uy = uy << 1; m = m << 1;
      end
      len = int_sqrt(ux * ux + uy * uy);
      qx = (ux * 65536 + len / 2) / len;
      qy = (uy * 65536 + len / 2) / len;
      if (qx > 65536) qx = 65536;
      if (qy > 65536) qy = 65536;
      ox = ax < 0 ? -32'(qx) : 32'(qx);
      oy = ay < 0 ? -32'(qy) : 32'(qy);
   endtask

   function automatic longint half_width(longint z);
      longint diff, w;
      longint unsigned prod, r;
      diff = z - longint'(m_zfar);
      prod = mag(diff) * mag(longint'(m_slope));
      r = (prod + 64'h8000) >> 16;
      w = ((diff < 0) != (m_slope < 0)) ? -longint'(r) : longint'(r);
      return sat32(w + longint'({1'b0, m_min_width}));
   endfunction

   task automatic place_corners(input logic signed [31:0] dx, input logic signed [31:0] dy);
      longint w, offx, offy;
      w = half_width(m_last_pt[2]);
      offx = round_shift(w * dx, 16);
      offy = round_shift(w * dy, 16);
      m_corners[0] = sat32(longint'(m_last_pt[0]) - offy);
      m_corners[1] = sat32(longint'(m_last_pt[1]) + offx);
      m_corners[2] = m_last_pt[2];
      m_corners[3] = m_last_pt[3];
      m_corners[4] = sat32(longint'(m_last_pt[0]) + offy);
      m_corners[5] = sat32(longint'(m_last_pt[1]) - offx);
      m_corners[6] = m_last_pt[2];
      m_corners[7] = m_last_pt[3];
      m_corner_nrm[0] = -dy;
      m_corner_nrm[1] = dx;
      m_corner_nrm[2] = dy;
      m_corner_nrm[3] = -dx;
   endtask

   function automatic logic [15:0] nrm_comp(longint n, longint unsigned len);
      longint unsigned q;
      longint v;
      q = (mag(n) * 32768 + len / 2) / len;
      if (n < 0) v = q > 32768 ? -32768 : -longint'(q);
      else v = q > 32767 ? 32767 : longint'(q);
      return v[15:0];
   endfunction

   task automatic stroke_point(input logic signed [31:0] px, input logic signed [31:0] py,
                               input logic signed [31:0] pz, input logic signed [31:0] pw);
      logic signed [31:0] v[4][4];
      logic signed [31:0] n[4][2];
      logic signed [31:0] ux, uy, bx, by;
      longint ddx, ddy, dot, nx, ny;
      longint unsigned len;
      int a, s, k;
      rsp_type r;
      if (m_count == 0) begin
         m_last_pt = '{px, py, pz, pw};
         m_count = 1;
         return;
      end
      ddx = longint'(px) - m_last_pt[0];
      ddy = longint'(py) - m_last_pt[1];
      if (ddx == 0 && ddy == 0) return;
      unit_dir(ddx, ddy, ux, uy);
      if (m_count == 1) begin
         place_corners(ux, uy);
         m_count = 2;
      end else begin
         a = m_sharp;
         m_sharp = 0;
         for (int i = 0; i < 4; i++) begin
            v[0][i] = m_corners[a * 4 + i];
            v[1][i] = m_corners[(1 - a) * 4 + i];
         end
         n[0][0] = m_corner_nrm[a * 2];
         n[0][1] = m_corner_nrm[a * 2 + 1];
         n[1][0] = m_corner_nrm[(1 - a) * 2];
         n[1][1] = m_corner_nrm[(1 - a) * 2 + 1];
         dot = longint'(m_last_dir[0]) * ux + longint'(m_last_dir[1]) * uy;
         if (dot > 0) begin
            unit_dir(longint'(m_last_dir[0]) + ux, longint'(m_last_dir[1]) + uy, bx, by);
         end else begin
            m_sharp = 1;
            unit_dir(longint'(m_last_dir[0]) - ux, longint'(m_last_dir[1]) - uy, bx, by);
         end
         place_corners(bx, by);
         for (int i = 0; i < 4; i++) begin
            v[2][i] = m_corners[i];
            v[3][i] = m_corners[4 + i];
         end
         n[2] = '{m_corner_nrm[0], m_corner_nrm[1]};
         n[3] = '{m_corner_nrm[2], m_corner_nrm[3]};
         k = 0;
         for (int t = 0; t < 2; t++) begin
            for (int c = 0; c < 3; c++) begin
               s = (t == 0) ? ((c == 0) ? 0 : (c == 1) ? 1 : 3)
                            : ((c == 0) ? 0 : (c == 1) ? 3 : 2);
               nx = n[s][0];
               ny = n[s][1];
               len = int_sqrt(longint'(nx * nx + ny * ny) + 64'd1073741824);
               r.out_x = v[s][0];
               r.out_y = v[s][1];
               r.out_z = v[s][2];
               r.out_w = v[s][3];
               r.normal_x = nrm_comp(nx, len);
               r.normal_y = nrm_comp(ny, len);
               r.normal_z = nrm_comp(-32768, len);
               r.tri_index = t[0];
               r.corner = c[1:0];
               r.last = (k == 5);
               expected_vertices.push_back(r);
               k++;
            end
         end
      end
      m_last_pt = '{px, py, pz, pw};
      m_last_dir = '{ux, uy};
   endtask

   task automatic predict_cmd(input req_type q);
      case (q.command)
         CMD_START: begin
            m_count = 0;
            m_sharp = 0;
         end
         CMD_POINT: stroke_point(q.pos_x, q.pos_y, q.pos_z, q.pos_w);
         CMD_END: stroke_point(32'(sat32(longint'(m_last_pt[0]) + m_last_dir[0])),
                               32'(sat32(longint'(m_last_pt[1]) + m_last_dir[1])),
                               m_last_pt[2], m_last_pt[3]);
         default: ;
      endcase
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver: predict at each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         send_gap <= 0;
      end else if (req_valid && req_ready) begin
         predict_cmd(req_data);
         void'(pending_cmds.pop_front());
         req_valid <= 0;
         send_gap <= $urandom_range(0, 8);
      end else if (!req_valid && pending_cmds.size() > 0) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else begin
            req_data <= pending_cmds[0];
            req_valid <= 1;
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected vertex %h", $realtime, rsp_data);
               errors++;
            end else begin
               e = expected_vertices.pop_front();
               if (e !== rsp_data)
                  $display("%0t: vertex mismatch expected %h actual %h", $realtime, e, rsp_data);
               if (e !== rsp_data) errors++;
            end
         end
         if (hold_off > 0) begin
            rsp_ready <= 0;
         end else if (rsp_valid && rsp_ready) begin
            recv_gap <= $urandom_range(0, 8);
            rsp_ready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_cmd(input logic [1:0] c, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] w);
      req_type q;
      q.command = c;
      q.pos_x = x;
      q.pos_y = y;
      q.pos_z = z;
      q.pos_w = w;
      pending_cmds.push_back(q);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      case (idx)
         REG_MIN_WIDTH: m_min_width = val[30:0];
         REG_WIDTH_SLOPE: m_slope = val;
         REG_Z_FAR: m_zfar = val;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_cmds.size() > 0 || req_valid || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   task automatic random_line(input int span);
      int pts;
      logic [31:0] bx, by;
      bx = $urandom;
      by = $urandom;
      push_cmd(CMD_START, $urandom, $urandom, $urandom, $urandom);
      pts = $urandom_range(2, 6);
      for (int i = 0; i < pts; i++) begin
         bx = bx + 32'($urandom_range(0, 2 * span)) - span;
         by = by + 32'($urandom_range(0, 2 * span)) - span;
         push_cmd(CMD_POINT, bx, by, $urandom, $urandom);
      end
      if ($urandom_range(0, 3) != 0) push_cmd(CMD_END, $urandom, $urandom, 0, 0);
   endtask

   initial begin
      errors = 0;
      cycle_count = 0;
      hold_off = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      csr_wr_en = 0;
      csr_index = REG_MIN_WIDTH;
      csr_data = '0;
      m_min_width = MIN_WIDTH_RESET;
      m_slope = 0;
      m_zfar = 0;
      m_count = 0;
      m_sharp = 0;
      m_last_pt = '{0, 0, 0, 0};
      m_last_dir = '{0, 0};
      m_corners = '{default: 0};
      m_corner_nrm = '{default: 0};
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: end with nothing, drop, sharp bends, extremes, unknown command
      push_cmd(CMD_END, 0, 0, 0, 0);
      push_cmd(CMD_START, 0, 0, 0, 0);
      push_cmd(CMD_POINT, 32'h0001_0000, 0, 32'h0002_0000, 32'h0001_0000);
      push_cmd(CMD_POINT, 32'h0001_0000, 0, 0, 0);
      push_cmd(CMD_POINT, 32'h0005_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000);
      push_cmd(CMD_POINT, 0, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
      push_cmd(CMD_POINT, 32'h0005_0000, 32'h0001_0000, 0, 0);
      push_cmd(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      push_cmd(CMD_END, 0, 0, 0, 0);
      push_cmd(CMD_START, 0, 0, 0, 0);
      push_cmd(CMD_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
      push_cmd(CMD_END, 0, 0, 0, 0);
      push_cmd(CMD_POINT, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0);
      push_cmd(CMD_POINT, 32'h7fff_ffff, 32'h8000_0000, 0, 32'hffff_ffff);
      push_cmd(CMD_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1234_5678, 0);
      push_cmd(CMD_END, 0, 0, 0, 0);
      drain();

      write_reg(REG_MIN_WIDTH, 32'h7fff_ffff);
      write_reg(REG_WIDTH_SLOPE, 32'h7fff_ffff);
      write_reg(REG_Z_FAR, 32'h8000_0000);
      for (int i = 0; i < 4; i++) random_line(1 << $urandom_range(0, 31));
      drain();

      write_reg(REG_MIN_WIDTH, 0);
      write_reg(REG_WIDTH_SLOPE, 32'h8000_0000);
      write_reg(REG_Z_FAR, 32'h7fff_ffff);
      for (int i = 0; i < 4; i++) random_line(1 << $urandom_range(0, 31));
      // stall the receiver while the sender keeps offering
      hold_off = 600;
      drain();

      write_reg(REG_MIN_WIDTH, 32'h0004_0000);
      write_reg(REG_WIDTH_SLOPE, 32'h0000_4000);
      write_reg(REG_Z_FAR, 32'h0010_0000);
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(0, 9) == 0) push_cmd(2'($urandom), $urandom, $urandom, $urandom, 0);
         else random_line(1 << $urandom_range(4, 26));
      end
      drain();

      write_reg(REG_MIN_WIDTH, $urandom);
      write_reg(REG_WIDTH_SLOPE, $urandom);
      write_reg(REG_Z_FAR, $urandom);
      for (int i = 0; i < 6; i++) random_line(1 << $urandom_range(8, 24));
      drain();

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
